>>> design/fe_pkg.sv
// ----------------------------------------------------------------------------
// fe_pkg
// shared constants, types and single-precision arithmetic functions of the
// float32_exp pipeline (round to nearest even, subnormal operands flushed)
// ----------------------------------------------------------------------------
package fe_pkg;

	localparam logic [31:0] ABS_MASK    = 32'h7fff_ffff;
	localparam logic [31:0] INF_BITS    = 32'h7f80_0000;
	localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
	localparam logic [31:0] BIG_LIMIT   = 32'h42b1_7218;
	localparam logic [31:0] HALF_LN2_HX = 32'h3eb1_7218;
	localparam logic [31:0] ONE5_LN2_HX = 32'h3f85_1592;

	localparam logic [31:0] HALF_F   = 32'h3f00_0000;
	localparam logic [31:0] INV_LN2  = 32'h3fb8_aa3b;
	localparam logic [31:0] LN2_HI   = 32'h3f31_7180;
	localparam logic [31:0] LN2_LO   = 32'h3717_f7d1;
	localparam logic [31:0] POLY1    = 32'h3f80_0000;
	localparam logic [31:0] POLY2    = 32'h3f00_0004;
	localparam logic [31:0] POLY3    = 32'h3e2a_a9a9;
	localparam logic [31:0] POLY4    = 32'h3d2a_cb77;
	localparam logic [31:0] POLY5    = 32'h3c06_6656;
	localparam logic [31:0] ONE_F    = 32'h3f80_0000;

	localparam int PolyStages = 10;

	// side data that travels with each transaction
	typedef struct packed {
		logic signed [8:0] k;
		logic              spec;
		logic [31:0]       spec_bits;
	} fe_side_t;

	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		logic        s;
		logic [47:0] p;
		logic [9:0]  e;
		logic [23:0] m;
		logic        g;
		logic        st;
		logic [24:0] mr;
		logic [31:0] res;
		s = a[31] ^ b[31];
		p = {1'b1, a[22:0]} * {1'b1, b[22:0]};
		if (p[47]) begin
			m  = p[47:24];
			g  = p[23];
			st = |p[22:0];
			e  = {2'b0, a[30:23]} + {2'b0, b[30:23]} - 10'd126;
		end else begin
			m  = p[46:23];
			g  = p[22];
			st = |p[21:0];
			e  = {2'b0, a[30:23]} + {2'b0, b[30:23]} - 10'd127;
		end
		mr = {1'b0, m} + {24'b0, g & (st | m[0])};
		if (mr[24]) begin
			mr = mr >> 1;
			e  = e + 10'd1;
		end
		if (a[30:23] == 8'd0 || b[30:23] == 8'd0)
			res = {s, 31'b0};
		else if ($signed(e) <= 10'sd0)
			res = {s, 31'b0};
		else if ($signed(e) >= 10'sd255)
			res = {s, 8'hff, 23'b0};
		else
			res = {s, e[7:0], mr[22:0]};
		return res;
	endfunction

	function automatic logic [31:0] fadd(input logic [31:0] a_in, input logic [31:0] b_in);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] bg;
		logic [31:0] sm;
		logic [8:0]  dd;
		logic [26:0] mb;
		logic [26:0] ms;
		logic [26:0] sh;
		logic [27:0] sum;
		logic [26:0] n;
		logic [9:0]  e;
		logic [4:0]  lz;
		logic        g;
		logic        st;
		logic [24:0] mr;
		logic [31:0] res;
		a = (a_in[30:23] == 8'd0) ? {a_in[31], 31'b0} : a_in;
		b = (b_in[30:23] == 8'd0) ? {b_in[31], 31'b0} : b_in;
		if (a[30:0] >= b[30:0]) begin
			bg = a;
			sm = b;
		end else begin
			bg = b;
			sm = a;
		end
		mb = {1'b1, bg[22:0], 3'b0};
		ms = (sm[30:23] == 8'd0) ? 27'd0 : {1'b1, sm[22:0], 3'b0};
		dd = {1'b0, bg[30:23]} - {1'b0, sm[30:23]};
		if (dd >= 9'd27)
			sh = {26'b0, |ms};
		else
			sh = (ms >> dd) | {26'b0, |(ms & ~({27{1'b1}} << dd))};
		if (bg[31] == sm[31])
			sum = {1'b0, mb} + {1'b0, sh};
		else
			sum = {1'b0, mb} - {1'b0, sh};
		e  = {2'b0, bg[30:23]};
		lz = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (sum[i])
				lz = 5'(26 - i);
		end
		if (sum[27]) begin
			n = {sum[27:2], sum[1] | sum[0]};
			e = e + 10'd1;
		end else begin
			n = sum[26:0] << lz;
			e = e - {5'b0, lz};
		end
		g  = n[2];
		st = |n[1:0];
		mr = {1'b0, n[26:3]} + {24'b0, g & (st | n[3])};
		if (mr[24]) begin
			mr = mr >> 1;
			e  = e + 10'd1;
		end
		if (bg[30:23] == 8'd0)
			res = {a[31] & b[31], 31'b0};
		else if (sum == 28'd0)
			res = 32'd0;
		else if ($signed(e) <= 10'sd0)
			res = {bg[31], 31'b0};
		else if ($signed(e) >= 10'sd255)
			res = {bg[31], 8'hff, 23'b0};
		else
			res = {bg[31], e[7:0], mr[22:0]};
		return res;
	endfunction

	// truncation toward zero, magnitude below 256
	function automatic logic signed [8:0] ftrunc(input logic [31:0] q);
		logic [2:0]  sh;
		logic [23:0] m;
		logic [7:0]  mag;
		sh = 3'(q[30:23] - 8'd127);
		m  = {1'b1, q[22:0]} >> (5'd23 - {2'b0, sh});
		if (q[30:23] < 8'd127)
			mag = 8'd0;
		else
			mag = m[7:0];
		return q[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	function automatic logic [31:0] itof(input logic signed [8:0] k);
		logic [7:0]  mag;
		logic [2:0]  p;
		logic [23:0] m;
		logic [31:0] res;
		mag = k[8] ? 8'(-k) : k[7:0];
		p   = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (mag[i])
				p = 3'(i);
		end
		m = {16'b0, mag} << (5'd23 - {2'b0, p});
		if (mag == 8'd0)
			res = 32'd0;
		else
			res = {k[8], 8'd127 + {5'b0, p}, m[22:0]};
		return res;
	endfunction

	function automatic logic [31:0] poly_coef(input logic [3:0] stage);
		logic [31:0] c;
		case (stage)
			4'd1:    c = POLY4;
			4'd3:    c = POLY3;
			4'd5:    c = POLY2;
			4'd7:    c = POLY1;
			default: c = ONE_F;
		endcase
		return c;
	endfunction

endpackage

>>> design/fe_reduce.sv
// ----------------------------------------------------------------------------
// fe_reduce
// argument classification and reduction r = x - k*ln2 over six stages
// ----------------------------------------------------------------------------
module fe_reduce (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [31:0]         x_bits,
	output logic                out_valid,
	output logic [31:0]         r,
	output fe_pkg::fe_side_t    side
);

	logic             valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic [31:0]      x_s1, x_s2, x_s3, x_s4;
	logic [31:0]      p_s1, q_s2, t_s3, th_s4, lo_s4, lo_s5, hi_s5, r_s6;
	logic             small_s1, small_s2, fast_s1, fast_s2;
	fe_pkg::fe_side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;

	logic [30:0]       mag;
	fe_pkg::fe_side_t  side_in;
	logic signed [8:0] k_d;

	always_comb begin
		mag               = x_bits[30:0];
		side_in.k         = 9'sd0;
		side_in.spec      = ({1'b0, mag} > fe_pkg::BIG_LIMIT);
		if ({1'b0, mag} > fe_pkg::INF_BITS)
			side_in.spec_bits = x_bits | fe_pkg::QUIET_BIT;
		else
			side_in.spec_bits = x_bits[31] ? 32'd0 : fe_pkg::INF_BITS;
	end

	always_comb begin
		if (small_s2)
			k_d = 9'sd0;
		else if (fast_s2)
			k_d = x_s2[31] ? -9'sd1 : 9'sd1;
		else
			k_d = fe_pkg::ftrunc(q_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: classify, p = x / ln2
		x_s1     <= x_bits;
		p_s1     <= fe_pkg::fmul(fe_pkg::INV_LN2, x_bits);
		small_s1 <= ({1'b0, mag} <= fe_pkg::HALF_LN2_HX);
		fast_s1  <= ({1'b0, mag} < fe_pkg::ONE5_LN2_HX);
		side_s1  <= side_in;
		// stage 2: q = p +- 0.5
		x_s2     <= x_s1;
		q_s2     <= fe_pkg::fadd(p_s1, {x_s1[31], fe_pkg::HALF_F[30:0]});
		small_s2 <= small_s1;
		fast_s2  <= fast_s1;
		side_s2  <= side_s1;
		// stage 3: k and its float value
		x_s3     <= x_s2;
		t_s3     <= fe_pkg::itof(k_d);
		side_s3  <= '{k: k_d, spec: side_s2.spec, spec_bits: side_s2.spec_bits};
		// stage 4: k*ln2 hi and lo
		x_s4     <= x_s3;
		th_s4    <= fe_pkg::fmul(t_s3, fe_pkg::LN2_HI);
		lo_s4    <= fe_pkg::fmul(t_s3, fe_pkg::LN2_LO);
		side_s4  <= side_s3;
		// stage 5: hi = x - k*ln2_hi
		hi_s5    <= fe_pkg::fadd(x_s4, {~th_s4[31], th_s4[30:0]});
		lo_s5    <= lo_s4;
		side_s5  <= side_s4;
		// stage 6: r = hi - lo
		r_s6     <= fe_pkg::fadd(hi_s5, {~lo_s5[31], lo_s5[30:0]});
		side_s6  <= side_s5;
	end

	assign out_valid = valid_s6;
	assign r         = r_s6;
	assign side      = side_s6;

endmodule

>>> design/fe_poly.sv
// ----------------------------------------------------------------------------
// fe_poly
// horner evaluation of 1 + r*(p1 + r*(p2 + r*(p3 + r*(p4 + r*p5)))),
// one multiply or add per stage
// ----------------------------------------------------------------------------
module fe_poly (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [31:0]      r,
	input  fe_pkg::fe_side_t in_side,
	output logic             out_valid,
	output logic [31:0]      y,
	output fe_pkg::fe_side_t out_side
);

	logic             valid_s [fe_pkg::PolyStages];
	logic [31:0]      r_s     [fe_pkg::PolyStages];
	logic [31:0]      acc_s   [fe_pkg::PolyStages];
	fe_pkg::fe_side_t side_s  [fe_pkg::PolyStages];

	for (genvar i = 0; i < fe_pkg::PolyStages; i++) begin : g_stage
		logic             v_in;
		logic [31:0]      r_in;
		logic [31:0]      a_in;
		fe_pkg::fe_side_t sd_in;
		logic [31:0]      acc_d;

		if (i == 0) begin : g_first
			assign v_in  = in_valid;
			assign r_in  = r;
			assign a_in  = fe_pkg::POLY5;
			assign sd_in = in_side;
		end else begin : g_next
			assign v_in  = valid_s[i-1];
			assign r_in  = r_s[i-1];
			assign a_in  = acc_s[i-1];
			assign sd_in = side_s[i-1];
		end

		if (i % 2 == 0) begin : g_mul
			assign acc_d = fe_pkg::fmul(r_in, a_in);
		end else begin : g_add
			assign acc_d = fe_pkg::fadd(fe_pkg::poly_coef(4'(i)), a_in);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else begin
				valid_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			r_s[i]    <= r_in;
			acc_s[i]  <= acc_d;
			side_s[i] <= sd_in;
		end
	end

	assign out_valid = valid_s[fe_pkg::PolyStages-1];
	assign y         = acc_s[fe_pkg::PolyStages-1];
	assign out_side  = side_s[fe_pkg::PolyStages-1];

endmodule

>>> design/float32_exp.sv
// ----------------------------------------------------------------------------
// float32_exp
// single-precision e^x on raw bit patterns, fully pipelined
// ----------------------------------------------------------------------------
// usage:
//   drive x_bits and raise start for one cycle per transaction; busy is
//   always low, so a new transaction may enter in every cycle
//   done is high for exactly one cycle with result_bits holding e^x
//   each transaction passes 6 reduction stages, 10 polynomial stages and
//   1 scaling stage on its way to the result
//   throughput: one transaction per cycle, set by one float multiply or
//   add per stage
//   nan returns a quiet nan, +inf and large positive give +inf,
//   -inf, large negative and underflow give +0
//   reset clears all stage valid bits; transactions in flight are dropped
//   the receiver cannot stall, results leave in order of entry
// ----------------------------------------------------------------------------
module float32_exp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] x_bits,
	output logic        done,
	output logic [31:0] result_bits
);

	logic             red_valid;
	logic [31:0]      red_r;
	fe_pkg::fe_side_t red_side;
	logic             poly_valid;
	logic [31:0]      poly_y;
	fe_pkg::fe_side_t poly_side;

	logic             done_q;
	logic [31:0]      result_q;
	logic signed [9:0] e_d;
	logic [31:0]      result_d;

	assign busy = 1'b0;

	fe_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.x_bits    (x_bits),
		.out_valid (red_valid),
		.r         (red_r),
		.side      (red_side)
	);

	fe_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (red_valid),
		.r         (red_r),
		.in_side   (red_side),
		.out_valid (poly_valid),
		.y         (poly_y),
		.out_side  (poly_side)
	);

	// add k to the exponent field; special results pass through, overflow gives +inf, underflow +0
	always_comb begin
		e_d = $signed({2'b0, poly_y[30:23]}) + {poly_side.k[8], poly_side.k};
		if (poly_side.spec)
			result_d = poly_side.spec_bits;
		else if (e_d >= 10'sd255)
			result_d = fe_pkg::INF_BITS;
		else if (e_d <= 10'sd0)
			result_d = 32'd0;
		else
			result_d = {poly_y[31], e_d[7:0], poly_y[22:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= poly_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign done        = done_q;
	assign result_bits = result_q;

endmodule
